// ----- hw/rtl/qcpm_pkg.sv -----
// ----------------------------------------------------------------------------
// qcpm_pkg
// Shared widths, constants, register map and types of the cascaded pid mixer.
// ----------------------------------------------------------------------------
package qcpm_pkg;

    // outer loop runs once every DIVIDER ticks
    localparam int DIVIDER = 4;
    localparam int DIV_W   = $clog2(DIVIDER + 1);

    // field and datapath widths
    localparam int GAIN_W  = 24;
    localparam int VAL_W   = 16;
    localparam int THR_W   = 11;
    localparam int LIM_W   = 15;
    localparam int MOTOR_W = 16;
    localparam int ERR_W   = VAL_W + 1;
    localparam int DIFF_W  = ERR_W + 1;
    localparam int AOUT_W  = 28;
    localparam int OPND_W  = AOUT_W + 1;
    localparam int FRAC_W  = 16;
    localparam int PROD_W  = GAIN_W + 1 + OPND_W;
    localparam int FPROD_W = PROD_W - FRAC_W;
    localparam int MIX_W   = FPROD_W + 1;

    // throttle scale: floor(thr * 128 / 5) = floor(thr * 128 * RECIP / 2^20)
    localparam int                THR_SHIFT     = 7;
    localparam int                U1_POST_SHIFT = 4;
    localparam logic [GAIN_W-1:0] U1_RECIP      = 24'd209716;

    // configuration port
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;
    localparam int APB_ADDR_W = REG_IDX_W + 2;

    localparam logic [REG_IDX_W-1:0] REG_KP_ANGLE    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_KI_ANGLE    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_KD_ANGLE    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_KP_RATE     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_INT_LIMIT   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_RATE_ONLY   = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_INT_ENABLE  = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_CTRL_ENABLE = 3'd7;

    localparam logic [GAIN_W-1:0] KP_ANGLE_RST  = 24'd983;
    localparam logic [GAIN_W-1:0] KI_ANGLE_RST  = 24'd0;
    localparam logic [GAIN_W-1:0] KD_ANGLE_RST  = 24'd0;
    localparam logic [GAIN_W-1:0] KP_RATE_RST   = 24'd13107;
    localparam logic [LIM_W-1:0]  INT_LIMIT_RST = 15'd2560;

    typedef struct packed {
        logic [GAIN_W-1:0] kp_angle;
        logic [GAIN_W-1:0] ki_angle;
        logic [GAIN_W-1:0] kd_angle;
        logic [GAIN_W-1:0] kp_rate;
        logic [LIM_W-1:0]  integral_limit;
        logic              rate_only;
        logic              integral_enable;
        logic              control_enable;
    } t_cfg;

    typedef struct packed {
        logic signed [VAL_W-1:0] target_roll;
        logic signed [VAL_W-1:0] target_pitch;
        logic signed [VAL_W-1:0] angle_roll;
        logic signed [VAL_W-1:0] angle_pitch;
        logic signed [VAL_W-1:0] rate_roll;
        logic signed [VAL_W-1:0] rate_pitch;
        logic [THR_W-1:0]        throttle;
    } t_in_item;

    typedef struct packed {
        logic [MOTOR_W-1:0] motor_front;
        logic [MOTOR_W-1:0] motor_right;
        logic [MOTOR_W-1:0] motor_back;
        logic [MOTOR_W-1:0] motor_left;
    } t_out_item;

endpackage

// ----- hw/rtl/qcpm_if.sv -----
// ----------------------------------------------------------------------------
// qcpm_if
// Valid/ready channels of the mixer: sensor tick in, motor speeds out.
// ----------------------------------------------------------------------------
interface qcpm_in_if;
    import qcpm_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] target_roll;
    logic signed [VAL_W-1:0] target_pitch;
    logic signed [VAL_W-1:0] angle_roll;
    logic signed [VAL_W-1:0] angle_pitch;
    logic signed [VAL_W-1:0] rate_roll;
    logic signed [VAL_W-1:0] rate_pitch;
    logic [THR_W-1:0]        throttle;

    modport source (
        output valid, target_roll, target_pitch, angle_roll, angle_pitch,
               rate_roll, rate_pitch, throttle,
        input  ready
    );
    modport sink (
        input  valid, target_roll, target_pitch, angle_roll, angle_pitch,
               rate_roll, rate_pitch, throttle,
        output ready
    );
endinterface

interface qcpm_out_if;
    import qcpm_pkg::*;

    logic               valid;
    logic               ready;
    logic [MOTOR_W-1:0] motor_front;
    logic [MOTOR_W-1:0] motor_right;
    logic [MOTOR_W-1:0] motor_back;
    logic [MOTOR_W-1:0] motor_left;

    modport source (
        output valid, motor_front, motor_right, motor_back, motor_left,
        input  ready
    );
    modport sink (
        input  valid, motor_front, motor_right, motor_back, motor_left,
        output ready
    );
endinterface

// ----- hw/rtl/qcpm_mac.sv -----
// ----------------------------------------------------------------------------
// qcpm_mac
// Shared gain multiplier: unsigned Q8.16 gain times signed value, product
// registered, floored back to the value's scale on the way out.
// ----------------------------------------------------------------------------
module qcpm_mac (
    input  logic                                  i_clk,
    input  logic [qcpm_pkg::GAIN_W-1:0]           i_gain,
    input  logic signed [qcpm_pkg::OPND_W-1:0]    i_opnd,
    output logic signed [qcpm_pkg::FPROD_W-1:0]   o_prod
);
    import qcpm_pkg::*;

    logic signed [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= $signed({1'b0, i_gain}) * i_opnd;
    end

    // dropping the fraction bits of a two's complement value floors it
    assign o_prod = r_prod[PROD_W-1:FRAC_W];

endmodule

// ----- hw/rtl/qcpm_regs.sv -----
// ----------------------------------------------------------------------------
// qcpm_regs
// Configuration register file behind an apb-style port.
// ----------------------------------------------------------------------------
module qcpm_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [qcpm_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [qcpm_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [qcpm_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    output qcpm_pkg::t_cfg                      o_cfg
);
    import qcpm_pkg::*;

    t_cfg                  r_cfg;
    logic [REG_IDX_W-1:0]  reg_idx;
    logic                  wr_en;

    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kp_angle        <= KP_ANGLE_RST;
            r_cfg.ki_angle        <= KI_ANGLE_RST;
            r_cfg.kd_angle        <= KD_ANGLE_RST;
            r_cfg.kp_rate         <= KP_RATE_RST;
            r_cfg.integral_limit  <= INT_LIMIT_RST;
            r_cfg.rate_only       <= 1'b0;
            r_cfg.integral_enable <= 1'b0;
            r_cfg.control_enable  <= 1'b1;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_KP_ANGLE:    r_cfg.kp_angle        <= pwdata[GAIN_W-1:0];
                REG_KI_ANGLE:    r_cfg.ki_angle        <= pwdata[GAIN_W-1:0];
                REG_KD_ANGLE:    r_cfg.kd_angle        <= pwdata[GAIN_W-1:0];
                REG_KP_RATE:     r_cfg.kp_rate         <= pwdata[GAIN_W-1:0];
                REG_INT_LIMIT:   r_cfg.integral_limit  <= pwdata[LIM_W-1:0];
                REG_RATE_ONLY:   r_cfg.rate_only       <= pwdata[0];
                REG_INT_ENABLE:  r_cfg.integral_enable <= pwdata[0];
                REG_CTRL_ENABLE: r_cfg.control_enable  <= pwdata[0];
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_KP_ANGLE:    prdata = {{(APB_DATA_W-GAIN_W){1'b0}}, r_cfg.kp_angle};
            REG_KI_ANGLE:    prdata = {{(APB_DATA_W-GAIN_W){1'b0}}, r_cfg.ki_angle};
            REG_KD_ANGLE:    prdata = {{(APB_DATA_W-GAIN_W){1'b0}}, r_cfg.kd_angle};
            REG_KP_RATE:     prdata = {{(APB_DATA_W-GAIN_W){1'b0}}, r_cfg.kp_rate};
            REG_INT_LIMIT:   prdata = {{(APB_DATA_W-LIM_W){1'b0}}, r_cfg.integral_limit};
            REG_RATE_ONLY:   prdata = {{(APB_DATA_W-1){1'b0}}, r_cfg.rate_only};
            REG_INT_ENABLE:  prdata = {{(APB_DATA_W-1){1'b0}}, r_cfg.integral_enable};
            REG_CTRL_ENABLE: prdata = {{(APB_DATA_W-1){1'b0}}, r_cfg.control_enable};
        endcase
    end

endmodule

// ----- hw/rtl/qcpm_ctrl.sv -----
// ----------------------------------------------------------------------------
// qcpm_ctrl
// Sequencer and loop state: walks both axes through the outer angle pid and
// the inner rate loop on one shared multiplier, then mixes the motor speeds.
// ----------------------------------------------------------------------------
module qcpm_ctrl (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  qcpm_pkg::t_cfg          i_cfg,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  qcpm_pkg::t_in_item      i_in_item,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output qcpm_pkg::t_out_item     o_out_item
);
    import qcpm_pkg::*;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_P    = 4'd1;  // issue kp * err
    localparam logic [3:0] ST_I    = 4'd2;  // take p, issue ki * err
    localparam logic [3:0] ST_D    = 4'd3;  // update integral, issue kd * delta
    localparam logic [3:0] ST_O    = 4'd4;  // angle loop output
    localparam logic [3:0] ST_R    = 4'd5;  // issue kp_rate * rate error
    localparam logic [3:0] ST_T    = 4'd6;  // take term, issue throttle scale
    localparam logic [3:0] ST_U    = 4'd7;  // take throttle term
    localparam logic [3:0] ST_M    = 4'd8;  // mix into output register

    function automatic logic [MOTOR_W-1:0] sat_motor(input logic signed [MIX_W-1:0] x);
        logic [MOTOR_W-1:0] res;
        if (x[MIX_W-1]) begin
            res = '0;
        end else if (|x[MIX_W-2:MOTOR_W]) begin
            res = '1;
        end else begin
            res = x[MOTOR_W-1:0];
        end
        return res;
    endfunction

    // control
    logic [3:0]        r_state;
    logic              r_ax;
    logic [DIV_W-1:0]  r_div;
    logic              r_out_valid;

    // loop state
    logic signed [ERR_W-1:0]  r_prev [2];
    logic signed [VAL_W-1:0]  r_int  [2];
    logic signed [AOUT_W-1:0] r_aout [2];

    // item payload and scratch
    logic signed [VAL_W-1:0]   r_target [2];
    logic signed [VAL_W-1:0]   r_angle  [2];
    logic signed [VAL_W-1:0]   r_rate   [2];
    logic [THR_W-1:0]          r_thr;
    logic                      r_run_outer;
    logic signed [AOUT_W-1:0]  r_p;
    logic signed [FPROD_W-1:0] r_term [2];
    logic [MOTOR_W-1:0]        r_u1;
    t_out_item                 r_out;

    logic                      in_acc;
    logic                      run_outer;
    logic                      out_load;
    logic signed [ERR_W-1:0]   err;
    logic signed [DIFF_W-1:0]  diff;
    logic signed [AOUT_W-1:0]  want;
    logic signed [OPND_W-1:0]  rerr;
    logic [GAIN_W-1:0]         mac_gain;
    logic signed [OPND_W-1:0]  mac_opnd;
    logic signed [FPROD_W-1:0] prod;
    logic signed [FPROD_W-1:0] int_sum;
    logic signed [FPROD_W-1:0] lim_pos;
    logic signed [FPROD_W-1:0] lim_neg;
    logic signed [VAL_W-1:0]   int_new;
    logic signed [AOUT_W-1:0]  aout_new;
    logic signed [MIX_W-1:0]   u1_ext;
    logic signed [MIX_W-1:0]   t_roll;
    logic signed [MIX_W-1:0]   t_pitch;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign in_acc      = i_in_valid & o_in_ready;
    assign run_outer   = !i_cfg.rate_only && (r_div >= DIV_W'(DIVIDER));
    assign out_load    = (r_state == ST_M) && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // per-axis operands
    assign err  = {r_target[r_ax][VAL_W-1], r_target[r_ax]}
                - {r_angle[r_ax][VAL_W-1], r_angle[r_ax]};
    assign diff = {err[ERR_W-1], err} - {r_prev[r_ax][ERR_W-1], r_prev[r_ax]};
    assign want = i_cfg.rate_only
                ? {{(AOUT_W-VAL_W){r_target[r_ax][VAL_W-1]}}, r_target[r_ax]}
                : r_aout[r_ax];
    assign rerr = {want[AOUT_W-1], want}
                - {{(OPND_W-VAL_W){r_rate[r_ax][VAL_W-1]}}, r_rate[r_ax]};

    always_comb begin
        unique case (r_state)
            ST_P: begin
                mac_gain = i_cfg.kp_angle;
                mac_opnd = {{(OPND_W-ERR_W){err[ERR_W-1]}}, err};
            end
            ST_I: begin
                mac_gain = i_cfg.ki_angle;
                mac_opnd = {{(OPND_W-ERR_W){err[ERR_W-1]}}, err};
            end
            ST_D: begin
                mac_gain = i_cfg.kd_angle;
                mac_opnd = {{(OPND_W-DIFF_W){diff[DIFF_W-1]}}, diff};
            end
            ST_R: begin
                mac_gain = i_cfg.kp_rate;
                mac_opnd = rerr;
            end
            ST_T: begin
                mac_gain = U1_RECIP;
                mac_opnd = {{(OPND_W-THR_W-THR_SHIFT){1'b0}}, r_thr, {THR_SHIFT{1'b0}}};
            end
            default: begin
                mac_gain = '0;
                mac_opnd = '0;
            end
        endcase
    end

    qcpm_mac u_mac (
        .i_clk  (i_clk),
        .i_gain (mac_gain),
        .i_opnd (mac_opnd),
        .o_prod (prod)
    );

    // integral with symmetric clamp, forced to zero when disabled
    assign int_sum = {{(FPROD_W-VAL_W){r_int[r_ax][VAL_W-1]}}, r_int[r_ax]} + prod;
    assign lim_pos = {{(FPROD_W-LIM_W){1'b0}}, i_cfg.integral_limit};
    assign lim_neg = -lim_pos;

    always_comb begin
        priority if (!i_cfg.integral_enable) begin
            int_new = '0;
        end else if (int_sum > lim_pos) begin
            int_new = lim_pos[VAL_W-1:0];
        end else if (int_sum < lim_neg) begin
            int_new = lim_neg[VAL_W-1:0];
        end else begin
            int_new = int_sum[VAL_W-1:0];
        end
    end

    // p + i + d, integral already updated in the previous step
    assign aout_new = r_p + {{(AOUT_W-VAL_W){r_int[r_ax][VAL_W-1]}}, r_int[r_ax]}
                    + prod[AOUT_W-1:0];

    assign u1_ext  = {{(MIX_W-MOTOR_W){1'b0}}, r_u1};
    assign t_roll  = {r_term[0][FPROD_W-1], r_term[0]};
    assign t_pitch = {r_term[1][FPROD_W-1], r_term[1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ax        <= 1'b0;
            r_div       <= DIV_W'(DIVIDER);
            r_out_valid <= 1'b0;
            for (int a = 0; a < 2; a++) begin
                r_prev[a] <= '0;
                r_int[a]  <= '0;
                r_aout[a] <= '0;
            end
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_ax    <= 1'b0;
                        r_state <= run_outer ? ST_P : ST_R;
                        // saturating tick count, restarted when the outer loop runs
                        if (run_outer) begin
                            r_div <= DIV_W'(1);
                        end else if (r_div < DIV_W'(DIVIDER)) begin
                            r_div <= r_div + DIV_W'(1);
                        end
                    end
                end
                ST_P: r_state <= ST_I;
                ST_I: r_state <= ST_D;
                ST_D: begin
                    r_int[r_ax] <= int_new;
                    r_state     <= ST_O;
                end
                ST_O: begin
                    r_aout[r_ax] <= aout_new;
                    r_prev[r_ax] <= err;
                    r_state      <= ST_R;
                end
                ST_R: r_state <= ST_T;
                ST_T: begin
                    if (!r_ax) begin
                        r_ax    <= 1'b1;
                        r_state <= r_run_outer ? ST_P : ST_R;
                    end else begin
                        r_state <= ST_U;
                    end
                end
                ST_U: r_state <= ST_M;
                ST_M: begin
                    if (out_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_target[0] <= i_in_item.target_roll;
            r_target[1] <= i_in_item.target_pitch;
            r_angle[0]  <= i_in_item.angle_roll;
            r_angle[1]  <= i_in_item.angle_pitch;
            r_rate[0]   <= i_in_item.rate_roll;
            r_rate[1]   <= i_in_item.rate_pitch;
            r_thr       <= i_in_item.throttle;
            r_run_outer <= run_outer;
        end
        if (r_state == ST_I) begin
            r_p <= prod[AOUT_W-1:0];
        end
        if (r_state == ST_T) begin
            r_term[r_ax] <= i_cfg.control_enable ? prod : '0;
        end
        if (r_state == ST_U) begin
            r_u1 <= prod[U1_POST_SHIFT +: MOTOR_W];
        end
        if (out_load) begin
            r_out.motor_front <= sat_motor(u1_ext + t_pitch);
            r_out.motor_right <= sat_motor(u1_ext + t_roll);
            r_out.motor_back  <= sat_motor(u1_ext - t_pitch);
            r_out.motor_left  <= sat_motor(u1_ext - t_roll);
        end
    end

endmodule

// ----- hw/rtl/quad_cascade_pid_mixer_core.sv -----
// ----------------------------------------------------------------------------
// quad_cascade_pid_mixer_core
// Cascaded angle/rate pid for roll and pitch with a plus-frame motor mixer.
//
//   port     dir   role
//   i_in     sink  one sensor tick: targets, angles, rates, throttle
//   o_out    src   four motor speeds per tick, Q8.8 clamped
//   apb      sink  gain, limit and mode registers
//
// An item holds the block for the rate loop of both axes in rate mode or on
// ticks that skip the outer loop, and for the outer angle pid too; every
// multiply goes through the one shared gain multiplier, one per cycle.
// The result sits in an output register, so the next tick is taken while it
// waits; a stalled output holds the sequencer in its final step.
// Synchronous active-low reset clears loop state and loads register defaults.
// ----------------------------------------------------------------------------
module quad_cascade_pid_mixer_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    qcpm_in_if.sink                             i_in,
    qcpm_out_if.source                          o_out,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [qcpm_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [qcpm_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [qcpm_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import qcpm_pkg::*;

    t_cfg      cfg;
    t_in_item  in_item;
    t_out_item out_item;

    assign in_item.target_roll  = i_in.target_roll;
    assign in_item.target_pitch = i_in.target_pitch;
    assign in_item.angle_roll   = i_in.angle_roll;
    assign in_item.angle_pitch  = i_in.angle_pitch;
    assign in_item.rate_roll    = i_in.rate_roll;
    assign in_item.rate_pitch   = i_in.rate_pitch;
    assign in_item.throttle     = i_in.throttle;

    assign o_out.motor_front = out_item.motor_front;
    assign o_out.motor_right = out_item.motor_right;
    assign o_out.motor_back  = out_item.motor_back;
    assign o_out.motor_left  = out_item.motor_left;

    qcpm_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    qcpm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_in_item   (in_item),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_out_item  (out_item)
    );

endmodule

// ----- hw/rtl/qcpm_chk.sv -----
// ----------------------------------------------------------------------------
// qcpm_chk
// Port-level checks of the mixer core, bound to the top level.
// ----------------------------------------------------------------------------
module qcpm_chk (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [qcpm_pkg::MOTOR_W-1:0]  i_motor_front,
    input  logic [qcpm_pkg::MOTOR_W-1:0]  i_motor_right,
    input  logic [qcpm_pkg::MOTOR_W-1:0]  i_motor_back,
    input  logic [qcpm_pkg::MOTOR_W-1:0]  i_motor_left,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pready
);
    import qcpm_pkg::*;

    // a stalled result keeps its speeds until the transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_motor_front)
            && $stable(i_motor_right) && $stable(i_motor_back) && $stable(i_motor_left))
        else $error("result dropped or changed while stalled");

    // reset empties the output register
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // the shared multiplier keeps the block busy after each input transfer
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready ##1 !i_in_ready)
        else $error("input taken while a tick is in progress");

    // register accesses never wait
    a_apb_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_psel && i_penable |-> i_pready)
        else $error("apb access stalled");

endmodule

bind quad_cascade_pid_mixer_core qcpm_chk u_qcpm_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_motor_front (o_out.motor_front),
    .i_motor_right (o_out.motor_right),
    .i_motor_back  (o_out.motor_back),
    .i_motor_left  (o_out.motor_left),
    .i_psel        (psel),
    .i_penable     (penable),
    .i_pready      (pready)
);

// ----- verif/qcpm_mixer_checker.sv -----
// ----------------------------------------------------------------------------
// qcpm_mixer_checker
// Watches the tick, motor and register ports of the cascaded pid mixer, keeps
// its own copy of loop state and registers, predicts the four motor speeds of
// every accepted tick and compares them in order with the results that leave.
// ----------------------------------------------------------------------------
module qcpm_mixer_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    qcpm_in_if                              i_tick,
    qcpm_out_if                             i_motor,
    input  logic                            i_psel,
    input  logic                            i_penable,
    input  logic                            i_pwrite,
    input  logic                            i_pready,
    input  logic [qcpm_pkg::APB_ADDR_W-1:0] i_paddr,
    input  logic [qcpm_pkg::APB_DATA_W-1:0] i_pwdata,
    output int                              o_mismatch_count,
    output int                              o_pending_count
);
    import qcpm_pkg::*;

    localparam int     REPORT_LIMIT = 10;
    localparam longint MOTOR_MAX    = 64'sd65535;
    localparam longint LOOP_MAX     = 64'sd2147483647;
    localparam longint LOOP_MIN     = -LOOP_MAX - 64'sd1;

    t_cfg                    cfg;
    logic signed [ERR_W-1:0] prev_err [2];
    logic signed [VAL_W-1:0] int_sum [2];
    logic signed [31:0]      loop_out [2];
    logic [DIV_W-1:0]        div_count;
    t_out_item               speeds_q [$];
    int                      mismatch_total;

    function automatic longint clip(longint v, longint lo, longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // gain * value in Q8.16 back to Q8.8, rounding toward minus infinity
    function automatic longint drop_frac(longint p);
        return p >>> FRAC_W;
    endfunction

    function automatic t_out_item predict_speeds(t_in_item tick);
        longint    tgt [2];
        longint    ang [2];
        longint    rt [2];
        longint    corr [2];
        longint    mot [4];
        longint    err, dterm, isum, rate_goal, thr_q, lim;
        t_out_item res;
        tgt[0] = longint'(tick.target_roll);
        tgt[1] = longint'(tick.target_pitch);
        ang[0] = longint'(tick.angle_roll);
        ang[1] = longint'(tick.angle_pitch);
        rt[0]  = longint'(tick.rate_roll);
        rt[1]  = longint'(tick.rate_pitch);
        thr_q  = longint'(tick.throttle) * 128 / 5;
        lim    = longint'(cfg.integral_limit);

        if (!cfg.rate_only && div_count >= DIVIDER) begin
            for (int a = 0; a < 2; a++) begin
                err   = tgt[a] - ang[a];
                dterm = drop_frac(longint'(cfg.kd_angle) * (err - longint'(prev_err[a])));
                if (cfg.integral_enable)
                    isum = clip(longint'(int_sum[a])
                                + drop_frac(longint'(cfg.ki_angle) * err), -lim, lim);
                else
                    isum = 0;
                int_sum[a]  = VAL_W'(isum);
                prev_err[a] = ERR_W'(err);
                loop_out[a] = 32'(clip(drop_frac(longint'(cfg.kp_angle) * err) + isum + dterm,
                                       LOOP_MIN, LOOP_MAX));
            end
            div_count = '0;
        end

        for (int a = 0; a < 2; a++) begin
            rate_goal = cfg.rate_only ? tgt[a] : longint'(loop_out[a]);
            corr[a]   = cfg.control_enable ?
                        drop_frac(longint'(cfg.kp_rate) * (rate_goal - rt[a])) : 0;
        end

        // plus frame: front/back on pitch, right/left on roll, no yaw
        mot[0] = thr_q + corr[1];
        mot[1] = thr_q + corr[0];
        mot[2] = thr_q - corr[1];
        mot[3] = thr_q - corr[0];
        res.motor_front = MOTOR_W'(clip(mot[0], 0, MOTOR_MAX));
        res.motor_right = MOTOR_W'(clip(mot[1], 0, MOTOR_MAX));
        res.motor_back  = MOTOR_W'(clip(mot[2], 0, MOTOR_MAX));
        res.motor_left  = MOTOR_W'(clip(mot[3], 0, MOTOR_MAX));

        if (div_count < DIVIDER)
            div_count = div_count + 1'b1;
        return res;
    endfunction

    task automatic flag_failure(input string msg);
        mismatch_total++;
        if (mismatch_total <= REPORT_LIMIT)
            $display("%0t %s", $realtime, msg);
    endtask

    always @(posedge i_clk) begin
        t_in_item  tick;
        t_out_item seen, want;
        if (!i_rst_n) begin
            cfg.kp_angle        = KP_ANGLE_RST;
            cfg.ki_angle        = KI_ANGLE_RST;
            cfg.kd_angle        = KD_ANGLE_RST;
            cfg.kp_rate         = KP_RATE_RST;
            cfg.integral_limit  = INT_LIMIT_RST;
            cfg.rate_only       = 1'b0;
            cfg.integral_enable = 1'b0;
            cfg.control_enable  = 1'b1;
            for (int a = 0; a < 2; a++) begin
                prev_err[a] = '0;
                int_sum[a]  = '0;
                loop_out[a] = '0;
            end
            div_count = DIV_W'(DIVIDER);
            speeds_q.delete();
        end else begin
            // retire the result first: a tick taken on this edge cannot be it
            if (i_motor.valid && i_motor.ready) begin
                seen = '{i_motor.motor_front, i_motor.motor_right,
                         i_motor.motor_back, i_motor.motor_left};
                if (speeds_q.size() == 0) begin
                    flag_failure($sformatf({"motor transfer with no tick pending:",
                                            " f=%0d r=%0d b=%0d l=%0d"},
                                           seen.motor_front, seen.motor_right,
                                           seen.motor_back, seen.motor_left));
                end else begin
                    want = speeds_q.pop_front();
                    if (seen.motor_front !== want.motor_front ||
                        seen.motor_right !== want.motor_right ||
                        seen.motor_back  !== want.motor_back  ||
                        seen.motor_left  !== want.motor_left) begin
                        flag_failure($sformatf({"motor mismatch: expected f=%0d r=%0d b=%0d l=%0d,",
                                                " got f=%0d r=%0d b=%0d l=%0d"},
                                               want.motor_front, want.motor_right,
                                               want.motor_back, want.motor_left,
                                               seen.motor_front, seen.motor_right,
                                               seen.motor_back, seen.motor_left));
                    end
                end
            end
            if (i_tick.valid && i_tick.ready) begin
                tick = '{i_tick.target_roll, i_tick.target_pitch, i_tick.angle_roll,
                         i_tick.angle_pitch, i_tick.rate_roll, i_tick.rate_pitch,
                         i_tick.throttle};
                speeds_q.push_back(predict_speeds(tick));
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[APB_ADDR_W-1:2])
                    REG_KP_ANGLE:    cfg.kp_angle        = i_pwdata[GAIN_W-1:0];
                    REG_KI_ANGLE:    cfg.ki_angle        = i_pwdata[GAIN_W-1:0];
                    REG_KD_ANGLE:    cfg.kd_angle        = i_pwdata[GAIN_W-1:0];
                    REG_KP_RATE:     cfg.kp_rate         = i_pwdata[GAIN_W-1:0];
                    REG_INT_LIMIT:   cfg.integral_limit  = i_pwdata[LIM_W-1:0];
                    REG_RATE_ONLY:   cfg.rate_only       = i_pwdata[0];
                    REG_INT_ENABLE:  cfg.integral_enable = i_pwdata[0];
                    REG_CTRL_ENABLE: cfg.control_enable  = i_pwdata[0];
                    default: ;
                endcase
            end
        end
        o_pending_count  <= speeds_q.size();
        o_mismatch_count <= mismatch_total;
    end

endmodule

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Regression of the cascaded pid mixer: directed corner ticks under extreme
// gain and mode settings, then random phases of drifting and noisy sensor
// ticks with random register settings, random stalls on both channels and
// one stretch of back-to-back transfers. Checking is done by the checker.
// ----------------------------------------------------------------------------
module tb;
    import qcpm_pkg::*;

    localparam int HALF_PERIOD    = 4;
    localparam int STALL_PCT      = 15;
    localparam int PHASES         = 8;
    localparam int TICKS_PER_PH   = 250;
    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 4000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int       mismatch_count;
    int       pending_ticks;
    int       quiet_cycles = 0;
    bit       steady_flow  = 1'b0;
    t_in_item walk;
    t_cfg     setting;

    qcpm_in_if  tick_bus ();
    qcpm_out_if motor_bus ();

    quad_cascade_pid_mixer_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (tick_bus),
        .o_out   (motor_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    qcpm_mixer_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_tick           (tick_bus),
        .i_motor          (motor_bus),
        .i_psel           (psel),
        .i_penable        (penable),
        .i_pwrite         (pwrite),
        .i_pready         (pready),
        .i_paddr          (paddr),
        .i_pwdata         (pwdata),
        .o_mismatch_count (mismatch_count),
        .o_pending_count  (pending_ticks)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    always @(negedge i_clk) begin
        if (!i_rst_n)
            motor_bus.ready <= 1'b0;
        else
            motor_bus.ready <= steady_flow || ($urandom_range(99) >= STALL_PCT);
    end

    // ends the run if no transfer of any kind happens for too long
    always @(posedge i_clk) begin
        if ((tick_bus.valid && tick_bus.ready) || (motor_bus.valid && motor_bus.ready) ||
            (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("quad_cascade_pid_mixer_core regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic put_tick(input t_in_item t);
        tick_bus.target_roll  = t.target_roll;
        tick_bus.target_pitch = t.target_pitch;
        tick_bus.angle_roll   = t.angle_roll;
        tick_bus.angle_pitch  = t.angle_pitch;
        tick_bus.rate_roll    = t.rate_roll;
        tick_bus.rate_pitch   = t.rate_pitch;
        tick_bus.throttle     = t.throttle;
    endtask

    // called and left at a falling edge
    task automatic send_tick(input t_in_item t);
        while (!steady_flow && $urandom_range(99) < STALL_PCT) begin
            tick_bus.valid = 1'b0;
            @(negedge i_clk);
        end
        tick_bus.valid = 1'b1;
        put_tick(t);
        @(posedge i_clk);
        while (!tick_bus.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        tick_bus.valid = 1'b0;
        while (pending_ticks != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [APB_DATA_W-1:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // unused upper data bits carry noise, the block has to drop them
    task automatic apply_setting(input t_cfg c);
        write_reg(REG_KP_ANGLE,    {8'($urandom), c.kp_angle});
        write_reg(REG_KI_ANGLE,    {8'($urandom), c.ki_angle});
        write_reg(REG_KD_ANGLE,    {8'($urandom), c.kd_angle});
        write_reg(REG_KP_RATE,     {8'($urandom), c.kp_rate});
        write_reg(REG_INT_LIMIT,   {17'($urandom), c.integral_limit});
        write_reg(REG_RATE_ONLY,   {31'($urandom), c.rate_only});
        write_reg(REG_INT_ENABLE,  {31'($urandom), c.integral_enable});
        write_reg(REG_CTRL_ENABLE, {31'($urandom), c.control_enable});
    endtask

    function automatic t_in_item mk_tick(int tr, int tp, int ar, int ap, int rr, int rp, int thr);
        t_in_item t;
        t.target_roll  = VAL_W'(tr);
        t.target_pitch = VAL_W'(tp);
        t.angle_roll   = VAL_W'(ar);
        t.angle_pitch  = VAL_W'(ap);
        t.rate_roll    = VAL_W'(rr);
        t.rate_pitch   = VAL_W'(rp);
        t.throttle     = THR_W'(thr);
        return t;
    endfunction

    function automatic logic [GAIN_W-1:0] pick_gain(int unsigned typical_max);
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 8)  return '0;
        if (roll < 16) return '1;
        if (roll < 24) return GAIN_W'($urandom);
        return GAIN_W'($urandom_range(typical_max));
    endfunction

    function automatic t_cfg pick_setting();
        t_cfg        c;
        int unsigned roll;
        c.kp_angle = pick_gain(1 << 18);
        c.ki_angle = pick_gain(1 << 15);
        c.kd_angle = pick_gain(1 << 17);
        c.kp_rate  = pick_gain(1 << 17);
        roll = $urandom_range(99);
        if (roll < 10)
            c.integral_limit = '0;
        else if (roll < 20)
            c.integral_limit = '1;
        else
            c.integral_limit = LIM_W'($urandom_range(8000));
        c.rate_only       = 1'b0;
        c.integral_enable = ($urandom_range(3) != 0);
        c.control_enable  = ($urandom_range(9) != 0);
        return c;
    endfunction

    function automatic logic signed [VAL_W-1:0] nudge(logic signed [VAL_W-1:0] v);
        int step;
        step = int'($urandom_range(512)) - 256;
        return VAL_W'(v + step);
    endfunction

    function automatic logic signed [VAL_W-1:0] near_zero();
        return VAL_W'(int'($urandom_range(8191)) - 4096);
    endfunction

    // mostly slowly drifting attitude so the integral builds up and clamps
    function automatic t_in_item pick_tick();
        int unsigned  roll;
        logic [127:0] noise;
        t_in_item     t;
        walk.target_roll  = nudge(walk.target_roll);
        walk.target_pitch = nudge(walk.target_pitch);
        walk.angle_roll   = nudge(walk.angle_roll);
        walk.angle_pitch  = nudge(walk.angle_pitch);
        walk.rate_roll    = nudge(walk.rate_roll);
        walk.rate_pitch   = nudge(walk.rate_pitch);
        walk.throttle     = THR_W'($urandom_range(2047));
        roll = $urandom_range(99);
        if (roll < 70) begin
            t = walk;
        end else if (roll < 90) begin
            t.target_roll  = near_zero();
            t.target_pitch = near_zero();
            t.angle_roll   = near_zero();
            t.angle_pitch  = near_zero();
            t.rate_roll    = near_zero();
            t.rate_pitch   = near_zero();
            t.throttle     = THR_W'($urandom_range(2047));
        end else begin
            noise = {$urandom, $urandom, $urandom, $urandom};
            t = noise[$bits(t_in_item)-1:0];
        end
        return t;
    endfunction

    task automatic run_directed();
        // register defaults, cascaded angle loop
        send_tick(mk_tick(0, 0, 0, 0, 0, 0, 0));
        send_tick(mk_tick(0, 0, 0, 0, 0, 0, 2047));
        send_tick(mk_tick(32767, 32767, -32768, -32768, -32768, -32768, 2047));
        send_tick(mk_tick(-32768, -32768, 32767, 32767, 32767, 32767, 0));
        send_tick(mk_tick(32767, -32768, -32768, 32767, 100, -100, 1000));
        send_tick(mk_tick(256, -256, 0, 0, 0, 0, 1024));
        wait_drained();

        // all gains at full scale, integral enabled but clamped to zero
        setting = '{kp_angle: '1, ki_angle: '1, kd_angle: '1, kp_rate: '1,
                    integral_limit: '0, rate_only: 1'b0, integral_enable: 1'b1,
                    control_enable: 1'b1};
        apply_setting(setting);
        send_tick(mk_tick(32767, -32768, -32768, 32767, 0, 0, 1024));
        send_tick(mk_tick(-32768, 32767, 32767, -32768, 5, -5, 2047));
        send_tick(mk_tick(1, -1, 0, 0, 0, 0, 512));
        wait_drained();

        // unity i, d and rate gains, zero p gain, widest integral clamp: drive the sum to both rails
        setting = '{kp_angle: '0, ki_angle: 24'h010000, kd_angle: 24'h010000,
                    kp_rate: 24'h010000, integral_limit: '1, rate_only: 1'b0,
                    integral_enable: 1'b1, control_enable: 1'b1};
        apply_setting(setting);
        repeat (4) send_tick(mk_tick(32767, 32767, -32768, -32768, 0, 0, 1024));
        repeat (4) send_tick(mk_tick(-32768, -32768, 32767, 32767, 0, 0, 1024));
        wait_drained();

        // rate mode with corrections switched off: throttle only
        setting = '{kp_angle: KP_ANGLE_RST, ki_angle: KI_ANGLE_RST, kd_angle: KD_ANGLE_RST,
                    kp_rate: '1, integral_limit: INT_LIMIT_RST, rate_only: 1'b1,
                    integral_enable: 1'b0, control_enable: 1'b0};
        apply_setting(setting);
        send_tick(mk_tick(32767, -32768, 0, 0, -32768, 32767, 2047));
        send_tick(mk_tick(-32768, 32767, 0, 0, 32767, -32768, 7));
        wait_drained();

        // rate mode, unity rate gain, largest rate errors
        setting.kp_rate        = 24'h010000;
        setting.control_enable = 1'b1;
        apply_setting(setting);
        send_tick(mk_tick(32767, 32767, 0, 0, -32768, -32768, 1024));
        send_tick(mk_tick(-32768, -32768, 0, 0, 32767, 32767, 1024));
        wait_drained();

        // first angle tick after rate mode runs the outer loop
        setting.rate_only = 1'b0;
        apply_setting(setting);
        send_tick(mk_tick(2560, -2560, 0, 0, 0, 0, 1024));
        wait_drained();
    endtask

    initial begin
        i_rst_n        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        tick_bus.valid = 1'b0;
        put_tick('0);
        motor_bus.ready = 1'b0;
        walk           = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        run_directed();

        for (int ph = 0; ph < PHASES; ph++) begin
            steady_flow = (ph == 3);
            setting = pick_setting();
            setting.rate_only = (ph % 3 == 1);
            apply_setting(setting);
            repeat (TICKS_PER_PH) send_tick(pick_tick());
            wait_drained();
        end
        steady_flow = 1'b0;

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_ticks == 0)
            $display("quad_cascade_pid_mixer_core regression: pass");
        else
            $display("quad_cascade_pid_mixer_core regression: fail");
        $finish;
    end

endmodule
